[rtl/userpass_auth_request_parser_assert.svh]
// ----------------------------------------------------------------------------
// userpass auth request parser assertion macros
// concurrent check macros used by the top-level rtl, removed with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef USERPASS_AUTH_REQUEST_PARSER_ASSERT_SVH
`define USERPASS_AUTH_REQUEST_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define UPAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upar check failed");

// next-cycle implication
`define UPAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upar check failed");

`else

`define UPAR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UPAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/upar_pkg.sv]
// ----------------------------------------------------------------------------
// upar_pkg
// shared types, status codes and helpers of the auth request parser
// ----------------------------------------------------------------------------
package upar_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;

    localparam logic [BYTE_W-1:0] SUPPORTED_VERSION_RESET = 8'd1;

    localparam logic [STATUS_W-1:0] STATUS_VER    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ULEN   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_USER   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_PLEN   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_PASS   = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_DONE   = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_BADVER = 3'd6;
    localparam logic [STATUS_W-1:0] STATUS_BADLEN = 3'd7;

    typedef enum logic [7:0] {
        ST_VER    = 8'b0000_0001,
        ST_ULEN   = 8'b0000_0010,
        ST_USER   = 8'b0000_0100,
        ST_PLEN   = 8'b0000_1000,
        ST_PASS   = 8'b0001_0000,
        ST_DONE   = 8'b0010_0000,
        ST_BADVER = 8'b0100_0000,
        ST_BADLEN = 8'b1000_0000
    } parse_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                data_valid;
        logic                data_is_password;
        logic [BYTE_W-1:0]   data_byte;
        logic                field_last;
    } upar_result_t;

    // valid flag handed between pipeline stages
    typedef struct packed {
        logic valid;
    } upar_hs_t;

    function automatic logic [STATUS_W-1:0] state_to_status(parse_state_t st);
        logic [STATUS_W-1:0] code;
        case (st)
            ST_VER:    code = STATUS_VER;
            ST_ULEN:   code = STATUS_ULEN;
            ST_USER:   code = STATUS_USER;
            ST_PLEN:   code = STATUS_PLEN;
            ST_PASS:   code = STATUS_PASS;
            ST_DONE:   code = STATUS_DONE;
            ST_BADVER: code = STATUS_BADVER;
            ST_BADLEN: code = STATUS_BADLEN;
            default:   code = STATUS_VER;
        endcase
        return code;
    endfunction

endpackage

[rtl/upar_in_stage.sv]
// ----------------------------------------------------------------------------
// upar_in_stage
// input register of the parser, holds one byte until the parse stage takes it
// ----------------------------------------------------------------------------
module upar_in_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [upar_pkg::BYTE_W-1:0] in_byte,
    input  logic                    advance,
    output upar_pkg::upar_hs_t      hs,
    output logic [upar_pkg::BYTE_W-1:0] byte_q
);
    import upar_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_byte;
        end
    end

    assign hs.valid = valid_reg;
    assign byte_q   = byte_reg;

endmodule

[rtl/upar_parse.sv]
// ----------------------------------------------------------------------------
// upar_parse
// parse state, field byte counter and per-byte result logic
// ----------------------------------------------------------------------------
module upar_parse (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [upar_pkg::BYTE_W-1:0] cfg_wr_data,
    input  logic                        advance,
    input  logic [upar_pkg::BYTE_W-1:0] byte_q,
    output upar_pkg::upar_result_t      result
);
    import upar_pkg::*;

    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic [BYTE_W-1:0] left_reg;
    logic [BYTE_W-1:0] left_next;
    logic [BYTE_W-1:0] version_reg;
    logic              is_last;

    // zero or one byte left means this is the last one
    assign is_last = (left_reg[BYTE_W-1:1] == '0);

    always_comb
    begin
        state_next              = state_reg;
        left_next               = left_reg;
        result.data_valid       = 1'b0;
        result.data_is_password = 1'b0;
        result.data_byte        = '0;
        result.field_last       = 1'b0;
        case (state_reg)
            ST_VER:
            begin
                state_next = (byte_q == version_reg) ? ST_ULEN : ST_BADVER;
            end
            ST_ULEN, ST_PLEN:
            begin
                if (byte_q == '0)
                begin
                    state_next = ST_BADLEN;
                end
                else
                begin
                    left_next  = byte_q;
                    state_next = (state_reg == ST_ULEN) ? ST_USER : ST_PASS;
                end
            end
            ST_USER, ST_PASS:
            begin
                result.data_valid       = 1'b1;
                result.data_is_password = (state_reg == ST_PASS);
                result.data_byte        = byte_q;
                if (is_last)
                begin
                    result.field_last = 1'b1;
                    left_next         = '0;
                    state_next        = (state_reg == ST_USER) ? ST_PLEN : ST_DONE;
                end
                else
                begin
                    left_next = left_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        result.status = state_to_status(state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_VER;
            left_reg    <= '0;
            version_reg <= SUPPORTED_VERSION_RESET;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                left_reg  <= left_next;
            end
            if (cfg_wr_en)
            begin
                version_reg <= cfg_wr_data;
            end
        end
    end

endmodule

[rtl/upar_out_stage.sv]
// ----------------------------------------------------------------------------
// upar_out_stage
// result register, decides when the parse stage may move a byte forward
// ----------------------------------------------------------------------------
module upar_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  upar_pkg::upar_hs_t     up_hs,
    input  upar_pkg::upar_result_t result,
    output logic                   advance,
    output logic                   out_valid,
    input  logic                   out_stall,
    output upar_pkg::upar_result_t result_q
);
    import upar_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    upar_result_t result_reg;

    assign advance    = up_hs.valid && (!valid_reg || !out_stall);
    assign valid_next = advance ? 1'b1 : (out_stall ? valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign result_q  = result_reg;

endmodule

[rtl/userpass_auth_request_parser.sv]
// ----------------------------------------------------------------------------
// userpass_auth_request_parser
// byte-wise parser of a username/password auth request, one result per byte
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   in      | sink      | in_valid / in_stall | in_byte
//   out     | source    | out_valid/out_stall | status, data_valid,
//           |           |                     | data_is_password, data_byte,
//           |           |                     | field_last
//   cfg     | sink      | cfg_wr_en           | cfg_wr_data (supported version)
//
// one byte per cycle sustained while out_stall is low; the input register loads
// at the transfer edge and the result register when the byte advances, and
// out_valid rises once the result register holds the byte
// the parse state updates in the same cycle the byte advances, so bytes never wait on it
// reset returns to reading the version byte, supported version back to 1
// out_stall holds the result register; in_stall rises only while the input
// register is full and the result register is stalled
// ----------------------------------------------------------------------------
`include "userpass_auth_request_parser_assert.svh"

module userpass_auth_request_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [upar_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          cfg_wr_en,
    input  logic [upar_pkg::BYTE_W-1:0]   cfg_wr_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [upar_pkg::STATUS_W-1:0] status,
    output logic                          data_valid,
    output logic                          data_is_password,
    output logic [upar_pkg::BYTE_W-1:0]   data_byte,
    output logic                          field_last
);
    import upar_pkg::*;

    upar_hs_t          in_hs;
    logic [BYTE_W-1:0] byte_q;
    logic              advance;
    upar_result_t      result;
    upar_result_t      result_q;

    upar_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .advance  (advance),
        .hs       (in_hs),
        .byte_q   (byte_q)
    );

    upar_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .byte_q      (byte_q),
        .result      (result)
    );

    upar_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_hs     (in_hs),
        .result    (result),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_q  (result_q)
    );

    assign status           = result_q.status;
    assign data_valid       = result_q.data_valid;
    assign data_is_password = result_q.data_is_password;
    assign data_byte        = result_q.data_byte;
    assign field_last       = result_q.field_last;

    // name bytes only while reading a field or right after its last byte
    `UPAR_ASSERT_IMPL(a_data_status, clk, rst_n, out_valid && data_valid,
        (status == STATUS_USER) || (status == STATUS_PLEN) ||
        (status == STATUS_PASS) || (status == STATUS_DONE))

    // last flag closes a field and moves on
    `UPAR_ASSERT_IMPL(a_last_status, clk, rst_n, out_valid && field_last,
        data_valid && ((status == STATUS_PLEN) || (status == STATUS_DONE)))

    // input backs up only behind a stalled result
    `UPAR_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // a stalled input keeps a result pending
    `UPAR_ASSERT_NEXT(a_stall_hold, clk, rst_n, in_stall, out_valid)

endmodule
